>>> hw/rtl/escaped_word_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// Escaped word tokenizer assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_WORD_TOKENIZER_MACROS_SVH
`define ESCAPED_WORD_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle that requires a consequence in the next cycle.
`define EWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EWT_ASSERT(lbl, prop, msg)
`define EWT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ewt_pkg.sv
// ---------------------------------------------------------------------------
// Escaped word tokenizer package
// Shared constants, state and result types of the tokenizer.
// ---------------------------------------------------------------------------
package ewt_pkg;

  localparam int unsigned MAX_WORD_LEN = 1024;
  localparam int unsigned WLEN_W       = $clog2(MAX_WORD_LEN + 1);

  localparam logic [WLEN_W-1:0] WLEN_MAX   = WLEN_W'(MAX_WORD_LEN);
  localparam logic [WLEN_W-1:0] WLEN_TRUNC = WLEN_W'(MAX_WORD_LEN - 1);

  // Result queue depth and the width of its fill count.
  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  // Parser phases.
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_WORD = 2'd1;
  localparam logic [1:0] PH_OCT  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  // Quote kinds.
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  // Characters the parser looks for.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;

  // Decoded values of the letter escapes.
  localparam logic [7:0] ESC_BEL = 8'h07;
  localparam logic [7:0] ESC_BS  = 8'h08;
  localparam logic [7:0] ESC_FF  = 8'h0C;
  localparam logic [7:0] ESC_LF  = 8'h0A;
  localparam logic [7:0] ESC_CR  = 8'h0D;
  localparam logic [7:0] ESC_SP  = 8'h20;
  localparam logic [7:0] ESC_TAB = 8'h09;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOS  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]        phase;
    logic              in_comment;
    logic              escape_pending;
    logic [1:0]        quote_kind;
    logic [8:0]        escape_value;
    logic [1:0]        digit_count;
    logic [WLEN_W-1:0] word_length;
    logic              newline_seen;
  } state_t;

  // All fields clear; the skip phase is code zero.
  localparam state_t ST_RESET = '0;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       starts_line;
    logic       overlong;
    logic       last;
  } entry_t;

  // Results of one input item, handed from the parser to the result queue.
  typedef struct packed {
    logic [1:0]       n;
    entry_t [2:0]     ent;
  } push_t;

  typedef struct packed {
    state_t st;
    push_t  push;
  } step_t;

endpackage

>>> hw/rtl/ewt_step.sv
// ---------------------------------------------------------------------------
// Escaped word tokenizer parser step
// Decodes one character against the parser state: next state and results.
// ---------------------------------------------------------------------------
module ewt_step (
  input  ewt_pkg::state_t state_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_input_i,
  output ewt_pkg::state_t state_o,
  output ewt_pkg::push_t  push_o
);

  import ewt_pkg::*;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // Bit 4 flags a hex digit, the low nibble is its value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic step_t put(step_t s, kind_e kind, logic [7:0] b, logic sl, logic ol);
    if (s.push.n != 2'd3) begin
      s.push.ent[s.push.n].kind        = kind;
      s.push.ent[s.push.n].out_byte    = b;
      s.push.ent[s.push.n].starts_line = sl;
      s.push.ent[s.push.n].overlong    = ol;
      s.push.ent[s.push.n].last        = 1'b0;
      s.push.n = s.push.n + 2'd1;
    end
    return s;
  endfunction

  // Characters past the truncation point are counted but not emitted.
  function automatic step_t store_char(step_t s, logic [7:0] v);
    if (s.st.word_length < WLEN_TRUNC) begin
      s = put(s, KIND_BYTE, v, 1'b0, 1'b0);
    end
    if (s.st.word_length < WLEN_MAX) begin
      s.st.word_length = s.st.word_length + WLEN_W'(1);
    end
    return s;
  endfunction

  function automatic step_t end_word(step_t s);
    s = put(s, KIND_END, 8'h00, s.st.newline_seen, s.st.word_length >= WLEN_MAX);
    s.st = ST_RESET;
    return s;
  endfunction

  function automatic step_t escaped_char(step_t s, logic [7:0] c);
    logic [7:0] v;
    logic       store;
    v     = c;
    store = (c != CH_NL);
    case (c)
      CH_A:    v = ESC_BEL;
      CH_B:    v = ESC_BS;
      CH_F:    v = ESC_FF;
      CH_N:    v = ESC_LF;
      CH_R:    v = ESC_CR;
      CH_S:    v = ESC_SP;
      CH_T:    v = ESC_TAB;
      default: begin
        if (is_oct(c)) begin
          s.st.escape_value = {6'd0, c[2:0]};
          s.st.digit_count  = 2'd1;
          s.st.phase        = PH_OCT;
          store             = 1'b0;
        end else if (c == CH_X) begin
          s.st.escape_value = 9'd0;
          s.st.digit_count  = 2'd0;
          s.st.phase        = PH_HEX;
          store             = 1'b0;
        end
      end
    endcase
    if (store) begin
      s = store_char(s, v);
    end
    return s;
  endfunction

  function automatic step_t skip_byte(step_t s, logic [7:0] c);
    if (c == CH_NL) begin
      // A backslash before the newline joins the lines.
      if (s.st.escape_pending) begin
        s.st.escape_pending = 1'b0;
      end else begin
        s.st.newline_seen = 1'b1;
        s.st.in_comment   = 1'b0;
      end
    end else if (s.st.in_comment) begin
      s.st.in_comment = 1'b1;
    end else if (s.st.escape_pending) begin
      s.st.escape_pending = 1'b0;
      s.st.phase          = PH_WORD;
      s.st.quote_kind     = Q_NONE;
      s = escaped_char(s, c);
    end else if (c == CH_BSL) begin
      s.st.escape_pending = 1'b1;
    end else if (c == CH_HASH || c == CH_SEMI) begin
      s.st.in_comment = 1'b1;
    end else if (!is_space(c)) begin
      s.st.phase = PH_WORD;
      if (c == CH_DQ) begin
        s.st.quote_kind = Q_DOUBLE;
      end else if (c == CH_SQ) begin
        s.st.quote_kind = Q_SINGLE;
      end else begin
        s.st.quote_kind = Q_NONE;
        s = store_char(s, c);
      end
    end
    return s;
  endfunction

  function automatic step_t word_byte(step_t s, logic [7:0] c);
    logic [7:0] q;
    q = (s.st.quote_kind == Q_DOUBLE) ? CH_DQ : CH_SQ;
    if (s.st.escape_pending) begin
      s.st.escape_pending = 1'b0;
      s = escaped_char(s, c);
    end else if (s.st.quote_kind != Q_NONE && c == q) begin
      s = end_word(s);
    end else if (s.st.quote_kind == Q_NONE && (is_space(c) || c == CH_HASH)) begin
      // The delimiter is then parsed as skipped text.
      s = end_word(s);
      s = skip_byte(s, c);
    end else if (c == CH_BSL) begin
      s.st.escape_pending = 1'b1;
    end else begin
      s = store_char(s, c);
    end
    return s;
  endfunction

  function automatic step_t finish_escape(step_t s);
    s.st.phase = PH_WORD;
    s = store_char(s, s.st.escape_value[7:0]);
    s.st.escape_value = 9'd0;
    s.st.digit_count  = 2'd0;
    return s;
  endfunction

  function automatic step_t oct_byte(step_t s, logic [7:0] c);
    if (is_oct(c)) begin
      s.st.escape_value = {s.st.escape_value[5:0], c[2:0]};
      s.st.digit_count  = s.st.digit_count + 2'd1;
      if (s.st.digit_count == 2'd3) begin
        s = finish_escape(s);
      end
    end else begin
      s = finish_escape(s);
      s = word_byte(s, c);
    end
    return s;
  endfunction

  function automatic step_t hex_byte(step_t s, logic [7:0] c);
    logic [4:0] d;
    d = hex_val(c);
    if (d[4]) begin
      s.st.escape_value = {s.st.escape_value[4:0], d[3:0]};
      s.st.digit_count  = s.st.digit_count + 2'd1;
      if (s.st.digit_count >= 2'd2) begin
        s = finish_escape(s);
      end
    end else begin
      s = finish_escape(s);
      s = word_byte(s, c);
    end
    return s;
  endfunction

  step_t s;

  always_comb begin
    s         = '0;
    s.st      = state_i;
    if (end_of_input_i) begin
      if (state_i.phase == PH_OCT || state_i.phase == PH_HEX) begin
        s = finish_escape(s);
      end
      if (s.st.phase == PH_WORD && s.st.word_length != '0) begin
        s = end_word(s);
      end
      s = put(s, KIND_EOS, 8'h00, 1'b0, 1'b0);
      s.st = ST_RESET;
    end else begin
      unique case (state_i.phase)
        PH_WORD: s = word_byte(s, in_byte_i);
        PH_OCT:  s = oct_byte(s, in_byte_i);
        PH_HEX:  s = hex_byte(s, in_byte_i);
        default: s = skip_byte(s, in_byte_i);
      endcase
    end
    if (s.push.n != 2'd0) begin
      s.push.ent[s.push.n - 2'd1].last = 1'b1;
    end
  end

  assign state_o = s.st;
  assign push_o  = s.push;

endmodule

>>> hw/rtl/ewt_outbuf.sv
// ---------------------------------------------------------------------------
// Escaped word tokenizer result queue
// Takes up to three results at once and hands them out one per transfer.
// ---------------------------------------------------------------------------
module ewt_outbuf (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_en_i,
  input  ewt_pkg::push_t                     push_i,
  output logic [ewt_pkg::OBUF_CNT_W-1:0]     space_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ewt_pkg::entry_t                    head_o
);

  import ewt_pkg::*;

  localparam int unsigned IDX_W = $clog2(OBUF_DEPTH);

  entry_t [OBUF_DEPTH-1:0] ent_q, ent_d;
  logic [OBUF_CNT_W-1:0]   cnt_q, cnt_d;
  logic [OBUF_CNT_W-1:0]   base;
  logic [OBUF_CNT_W-1:0]   idx;
  logic [OBUF_CNT_W-1:0]   push_n;
  logic                    pop;

  assign pop    = (cnt_q != '0) && !out_stall_i;
  assign push_n = push_en_i ? OBUF_CNT_W'(push_i.n) : '0;
  assign base   = cnt_q - OBUF_CNT_W'(pop);

  // Shift out the head on a transfer, then append behind the survivors.
  always_comb begin
    ent_d = ent_q;
    idx   = '0;
    if (pop) begin
      for (int i = 0; i < OBUF_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    for (int j = 0; j < 3; j++) begin
      idx = base + OBUF_CNT_W'(j);
      if (OBUF_CNT_W'(j) < push_n) begin
        ent_d[idx[IDX_W-1:0]] = push_i.ent[j];
      end
    end
    cnt_d = base + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign space_o     = OBUF_CNT_W'(OBUF_DEPTH) - cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = ent_q[0];

endmodule

>>> hw/rtl/escaped_word_tokenizer.sv
// ---------------------------------------------------------------------------
// Escaped word tokenizer
// Splits configuration text into words with quoting, comments and escapes.
// ---------------------------------------------------------------------------
// The block takes one text byte per cycle unless in_stall_o is high. A byte
// goes into an input register, is decoded combinationally against the parser
// state, and its zero to three results land in a four-entry result queue,
// from whose head they are offered. The output side moves one result per
// cycle while out_stall_i is low. The input stalls only while the queue,
// counted before this cycle's output transfer, lacks room for all results
// of the registered byte, so the sustained rate is one byte per cycle when
// bytes give at most one result each on average and the output is not
// stalled.
// ---------------------------------------------------------------------------
`include "escaped_word_tokenizer_macros.svh"

module escaped_word_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       starts_line_o,
  output logic       overlong_o,
  output logic       last_o
);

  import ewt_pkg::*;

  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  in_eof_q;
  logic                  accept;
  logic                  fire;
  state_t                state_q, state_d;
  push_t                 push;
  logic [OBUF_CNT_W-1:0] space;
  entry_t                head;

  ewt_step u_step (
    .state_i        (state_q),
    .in_byte_i      (in_byte_q),
    .end_of_input_i (in_eof_q),
    .state_o        (state_d),
    .push_o         (push)
  );

  // The registered byte is parsed once the queue can hold all its results.
  assign fire       = in_vld_q && (OBUF_CNT_W'(push.n) <= space);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= ST_RESET;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
      in_eof_q  <= end_of_input_i;
    end
  end

  ewt_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign out_byte_o    = head.out_byte;
  assign starts_line_o = head.starts_line;
  assign overlong_o    = head.overlong;
  assign last_o        = head.last;

  `EWT_ASSERT_NEXT(a_eof_clears_state, fire && in_eof_q, state_q == ST_RESET, "state not cleared after end of input")
  `EWT_ASSERT_NEXT(a_held_item, in_vld_q && !fire, in_vld_q && $stable(in_byte_q), "waiting byte lost")
  `EWT_ASSERT(a_wlen_sat, state_q.word_length <= WLEN_MAX, "word length beyond saturation")

endmodule
